// ===== hw/rtl/xce_pkg.sv =====
// ----------------------------------------------------------------------------
// xce_pkg
// Shared types, constants and entity text for the XML character escaper.
// ----------------------------------------------------------------------------
package xce_pkg;

   localparam int CP_W       = 21;
   localparam int CHAR_W     = 7;
   localparam int DIGIT_W    = 4;
   localparam int MAX_DIGITS = 7;
   localparam int ND_W       = $clog2(MAX_DIGITS + 1);
   localparam int DIDX_W     = $clog2(MAX_DIGITS);
   localparam int POS_W      = 4;

   localparam logic [CP_W-1:0] ASCII_TOP = CP_W'(8'h7F);

   localparam logic [CHAR_W-1:0] CH_AMP   = 7'h26;
   localparam logic [CHAR_W-1:0] CH_LT    = 7'h3C;
   localparam logic [CHAR_W-1:0] CH_GT    = 7'h3E;
   localparam logic [CHAR_W-1:0] CH_QUOT  = 7'h22;
   localparam logic [CHAR_W-1:0] CH_APOS  = 7'h27;
   localparam logic [CHAR_W-1:0] CH_HASH  = 7'h23;
   localparam logic [CHAR_W-1:0] CH_SEMI  = 7'h3B;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

   // entity text, left aligned in six byte slots
   localparam logic [47:0] TXT_AMP  = {"&amp;", 8'h00};
   localparam logic [47:0] TXT_LT   = {"&lt;", 16'h0000};
   localparam logic [47:0] TXT_GT   = {"&gt;", 16'h0000};
   localparam logic [47:0] TXT_QUOT = "&quot;";
   localparam logic [47:0] TXT_APOS = "&apos;";

   typedef enum logic [2:0] {
      KIND_PASS = 3'd0,
      KIND_AMP  = 3'd1,
      KIND_LT   = 3'd2,
      KIND_GT   = 3'd3,
      KIND_QUOT = 3'd4,
      KIND_APOS = 3'd5,
      KIND_NUM  = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic [CP_W-1:0]    quot;
      logic [DIGIT_W-1:0] rem;
   } div_result_type;

   function automatic kind_type classify(input logic [CP_W-1:0] cp);
      kind_type k;
      k = KIND_PASS;
      if (cp > ASCII_TOP)                     k = KIND_NUM;
      else if (cp[CHAR_W-1:0] == CH_AMP)      k = KIND_AMP;
      else if (cp[CHAR_W-1:0] == CH_LT)       k = KIND_LT;
      else if (cp[CHAR_W-1:0] == CH_GT)       k = KIND_GT;
      else if (cp[CHAR_W-1:0] == CH_QUOT)     k = KIND_QUOT;
      else if (cp[CHAR_W-1:0] == CH_APOS)     k = KIND_APOS;
      return k;
   endfunction

   // index of the last character of an entity
   function automatic logic [POS_W-1:0] ent_last(input kind_type k);
      logic [POS_W-1:0] n;
      unique case (k)
         KIND_AMP:            n = 4'd4;
         KIND_LT, KIND_GT:    n = 4'd3;
         KIND_QUOT, KIND_APOS: n = 4'd5;
         default:             n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] ent_char(input kind_type k,
                                                  input logic [POS_W-1:0] pos);
      logic [47:0] txt;
      logic [2:0]  sel;
      unique case (k)
         KIND_AMP:  txt = TXT_AMP;
         KIND_LT:   txt = TXT_LT;
         KIND_GT:   txt = TXT_GT;
         KIND_QUOT: txt = TXT_QUOT;
         KIND_APOS: txt = TXT_APOS;
         default:   txt = '0;
      endcase
      sel = 3'd5 - pos[2:0];
      return txt[{sel, 3'b000} +: CHAR_W];
   endfunction

endpackage

// ===== hw/rtl/xce_div10.sv =====
// ----------------------------------------------------------------------------
// xce_div10
// Divide by ten with remainder, by reciprocal multiply, in combinational logic.
// ----------------------------------------------------------------------------
module xce_div10 (
   input  logic [xce_pkg::CP_W-1:0] value,
   output xce_pkg::div_result_type  result
);
   import xce_pkg::*;

   // ceil(2^24 / 10); exact for every 21-bit value
   localparam logic [CP_W-1:0] RECIP = CP_W'(1677722);

   logic [2*CP_W-1:0] prod;
   logic [CP_W-1:0]   quot;
   logic [CP_W-1:0]   q10;
   logic [CP_W-1:0]   diff;

   assign prod = {{CP_W{1'b0}}, value} * {{CP_W{1'b0}}, RECIP};
   assign quot = {3'b000, prod[2*CP_W-1:24]};
   assign q10  = {quot[CP_W-4:0], 3'b000} + {quot[CP_W-2:0], 1'b0};
   assign diff = value - q10;

   assign result.quot = quot;
   assign result.rem  = diff[DIGIT_W-1:0];

endmodule

// ===== hw/rtl/xml_character_escaper_unit.sv =====
// ----------------------------------------------------------------------------
// xml_character_escaper_unit
// Escapes one code point per input beat into a run of ASCII result beats.
// ----------------------------------------------------------------------------
// An accepted code point is registered into the sequencer, which converts
//   numeric references to decimal digits (1..7) and then emits the run into
//   the output register. One result beat per cycle while emitting, unless the
//   output is stalled; a new code point is accepted only once the sequencer
//   is idle again, after the last beat of the previous run has been emitted.
// Reset: synchronous, active high; clears the sequencer and output valid.
module xml_character_escaper_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [xce_pkg::CP_W-1:0]   req_code_point,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [xce_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_run_end
);
   import xce_pkg::*;

   // sequencer
   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [CP_W-1:0]   value_ff, value_in;   // remaining value during conversion
   logic [CHAR_W-1:0] pass_ff, pass_in;     // plain character
   logic [ND_W-1:0]   nd_ff, nd_in;         // digits produced
   logic [POS_W-1:0]  pos_ff, pos_in;       // character index within run

   // digit store, least significant first
   logic [DIGIT_W-1:0] digits_ff [MAX_DIGITS];

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              out_end_ff, out_end_in;

   div_result_type    div_res;

   logic              req_take;
   logic              out_free;
   logic              emit_fire;
   logic              emit_last;
   logic [CHAR_W-1:0] emit_char;
   logic [POS_W-1:0]  num_last;
   logic [POS_W-1:0]  didx_full;
   logic [DIDX_W-1:0] didx;
   logic [ND_W-1:0]   nd_next;

   xce_div10 u_div10 (
      .value  (value_ff),
      .result (div_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // output register accepts a new beat when empty or draining this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign emit_fire = (state_ff == ST_EMIT) && out_free;

   // numeric run: '&' '#' digits (most significant first) ';'
   assign num_last  = {1'b0, nd_ff} + 4'd2;
   assign didx_full = {1'b0, nd_ff} + 4'd1 - pos_ff;
   assign didx      = didx_full[DIDX_W-1:0];
   assign nd_next   = nd_ff + 3'd1;

   always_comb begin
      emit_char = pass_ff;
      emit_last = 1'b1;
      unique case (kind_ff)
         KIND_PASS: begin
            emit_char = pass_ff;
            emit_last = 1'b1;
         end
         KIND_NUM: begin
            emit_last = (pos_ff == num_last);
            if (pos_ff == 4'd0)       emit_char = CH_AMP;
            else if (pos_ff == 4'd1)  emit_char = CH_HASH;
            else if (emit_last)       emit_char = CH_SEMI;
            else                      emit_char = CH_ZERO | {3'b000, digits_ff[didx]};
         end
         default: begin
            emit_char = ent_char(kind_ff, pos_ff);
            emit_last = (pos_ff == ent_last(kind_ff));
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      pass_in  = pass_ff;
      nd_in    = nd_ff;
      pos_in   = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in  = classify(req_code_point);
               value_in = req_code_point;
               pass_in  = req_code_point[CHAR_W-1:0];
               nd_in    = '0;
               pos_in   = '0;
               state_in = (req_code_point > ASCII_TOP) ? ST_CONV : ST_EMIT;
            end
         end
         ST_CONV: begin
            // one digit per cycle; stop on zero quotient or digit limit
            value_in = div_res.quot;
            nd_in    = nd_next;
            if (div_res.quot == '0 || nd_next == ND_W'(MAX_DIGITS))
               state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               pos_in = pos_ff + 4'd1;
               if (emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_end_in   = out_end_ff;
      if (emit_fire) begin
         out_valid_in = 1'b1;
         out_char_in  = emit_char;
         out_end_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      pass_ff     <= pass_in;
      nd_ff       <= nd_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_end_ff  <= out_end_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CONV) digits_ff[nd_ff[DIDX_W-1:0]] <= div_res.rem;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_run_end  = out_end_ff;

   // a beat that is not the end of its run means the rest is still coming
   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_end_ff) |-> (state_ff == ST_EMIT))
      else $error("non-final beat held while sequencer not emitting");

   // conversion never runs past the digit store
   a_conv_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (nd_ff < ND_W'(MAX_DIGITS)))
      else $error("digit count overran store");

   // conversion only ends into emission
   a_conv_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |=> (state_ff == ST_CONV || state_ff == ST_EMIT))
      else $error("conversion left to wrong state");

   // a numeric run starts with digits already converted
   a_num_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && kind_ff == KIND_NUM) |-> (nd_ff != '0))
      else $error("numeric run without digits");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for xml_character_escaper_unit. Code points go in one
// per beat; every escaped character coming back is checked, in order,
// against a run predicted here when the code point is accepted.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import xce_pkg::*;

   // one escaped character as it should appear on the result channel
   typedef struct {
      logic [CHAR_W-1:0] out_char;
      logic              run_end;
   } esc_beat_type;

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [CP_W-1:0]   req_code_point = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [CHAR_W-1:0] rsp_out_char;
   logic              rsp_run_end;

   // escaped characters still owed by the block, oldest first
   esc_beat_type escaped_chars[$];

   // idle rates in percent, per side; zero gives back-to-back beats
   int send_idle_pct  = 10;
   int recv_stall_pct = 10;

   int items_sent      = 0;
   int numeric_items   = 0;
   int entity_items    = 0;
   int beats_checked   = 0;
   int mismatches      = 0;

   xml_character_escaper_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_end    (rsp_run_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop; far beyond the slowest legal run of ~230 items
   initial begin
      #2ms;
      $display("Timeout at %0t with %0d characters still owed",
               $time, escaped_chars.size());
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor: append the escaped run of one code point
   // ------------------------------------------------------------------
   function automatic void push_char(logic [CHAR_W-1:0] ch, logic last);
      esc_beat_type b;
      b.out_char = ch;
      b.run_end  = last;
      escaped_chars.insert(escaped_chars.size(), b);
   endfunction

   function automatic void push_text(string txt);
      byte ch;
      for (int i = 0; i < txt.len(); i++) begin
         ch = txt[i];
         push_char(ch[CHAR_W-1:0], i == txt.len() - 1);
      end
   endfunction

   function automatic void predict_escape(logic [CP_W-1:0] cp);
      int unsigned value;
      int          nd;
      logic [3:0]  digits[MAX_DIGITS];
      value = cp;
      nd    = 0;
      if (cp > ASCII_TOP) begin
         // decimal reference, most significant digit first, no leading zeros
         numeric_items++;
         do begin
            digits[nd] = 4'(value % 10);
            value      = value / 10;
            nd++;
         end while (value != 0);
         push_char(CH_AMP, 1'b0);
         push_char(CH_HASH, 1'b0);
         for (int i = nd - 1; i >= 0; i--)
            push_char(CH_ZERO + CHAR_W'(digits[i]), 1'b0);
         push_char(CH_SEMI, 1'b1);
      end else begin
         // upper bits are zero here, so the low seven bits are the character
         case (cp[CHAR_W-1:0])
            CH_AMP:  begin push_text("&amp;");  entity_items++; end
            CH_LT:   begin push_text("&lt;");   entity_items++; end
            CH_GT:   begin push_text("&gt;");   entity_items++; end
            CH_QUOT: begin push_text("&quot;"); entity_items++; end
            CH_APOS: begin push_text("&apos;"); entity_items++; end
            default: push_char(cp[CHAR_W-1:0], 1'b1);
         endcase
      end
   endfunction

   // ------------------------------------------------------------------
   // Sender: one code point per call. Valid stays high from one beat to
   // the next unless an idle cycle is drawn, so it is never dropped and
   // raised at the same edge.
   // ------------------------------------------------------------------
   task automatic send_code_point(logic [CP_W-1:0] cp);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_code_point <= cp;
      // accepted at the first rising edge with stall low
      do @(posedge clock); while (req_stall);
      predict_escape(cp);
      items_sent++;
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall, changed only on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // ------------------------------------------------------------------
   // Checker: every result beat against the oldest owed character
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      esc_beat_type exp_b;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (escaped_chars.size() == 0) begin
            $display("%0t: unexpected beat char=0x%02h run_end=%0b",
                     $time, rsp_out_char, rsp_run_end);
            mismatches++;
         end else begin
            exp_b = escaped_chars.pop_front();
            if (rsp_out_char !== exp_b.out_char) begin
               $display("%0t: out_char expected 0x%02h actual 0x%02h",
                        $time, exp_b.out_char, rsp_out_char);
               mismatches++;
            end
            if (rsp_run_end !== exp_b.run_end) begin
               $display("%0t: run_end expected %0b actual %0b",
                        $time, exp_b.run_end, rsp_run_end);
               mismatches++;
            end
            beats_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // ASCII that passes through unchanged, zero and the top of the range
   task automatic test_plain_chars();
      send_code_point(21'h000000);
      send_code_point(21'h000001);
      send_code_point(21'h000020);
      send_code_point(21'h000041);
      send_code_point(21'h00007E);
      send_code_point(21'h00007F);
   endtask

   // the five markup characters, the ampersand twice
   task automatic test_markup_entities();
      send_code_point(CP_W'(CH_AMP));
      send_code_point(CP_W'(CH_LT));
      send_code_point(CP_W'(CH_GT));
      send_code_point(CP_W'(CH_QUOT));
      send_code_point(CP_W'(CH_APOS));
      send_code_point(CP_W'(CH_AMP));
   endtask

   // numeric references: first one above ASCII, digit-count boundaries,
   // surrogates, the Unicode top and the 21-bit values beyond it
   task automatic test_numeric_refs();
      send_code_point(21'h000080);
      send_code_point(21'h000126);   // low bits look like an ampersand
      send_code_point(21'h00013C);   // low bits look like a less-than
      send_code_point(21'h0003E7);   // 999
      send_code_point(21'h0003E8);   // 1000
      send_code_point(21'h00D800);
      send_code_point(21'h00DFFF);
      send_code_point(21'h00FFFF);
      send_code_point(21'h0F423F);   // 999999
      send_code_point(21'h0F4240);   // 1000000, first seven-digit value
      send_code_point(21'h10FFFF);
      send_code_point(21'h110000);
      send_code_point(21'h1FFFFF);   // longest run, ten characters
   endtask

   function automatic logic [CP_W-1:0] pick_code_point();
      int sel;
      sel = $urandom_range(99);
      if (sel < 25) begin
         case ($urandom_range(4))
            0:       return CP_W'(CH_AMP);
            1:       return CP_W'(CH_LT);
            2:       return CP_W'(CH_GT);
            3:       return CP_W'(CH_QUOT);
            default: return CP_W'(CH_APOS);
         endcase
      end else if (sel < 50) begin
         return CP_W'($urandom_range(127));
      end else if (sel < 70) begin
         return CP_W'($urandom_range(16'hFFFF, 8'h80));
      end else if (sel < 85) begin
         return CP_W'($urandom_range(21'h10FFFF, 21'h10000));
      end else begin
         return CP_W'($urandom());   // full 21-bit space, beyond Unicode too
      end
   endfunction

   task automatic test_random_mix(int count);
      repeat (count) send_code_point(pick_code_point());
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_chars();
      test_markup_entities();
      test_numeric_refs();

      test_random_mix(80);
      // long stretch with both sides running flat out
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_mix(70);
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      test_random_mix(55);

      @(negedge clock);
      req_valid <= 1'b0;

      while (escaped_chars.size() != 0) @(posedge clock);
      // room for any stray beat after the last owed one
      repeat (40) @(posedge clock);

      $display("Sent %0d code points (%0d numeric, %0d entities); checked %0d characters",
               items_sent, numeric_items, entity_items, beats_checked);
      $display("Mismatches: %0d, characters left owed: %0d",
               mismatches, escaped_chars.size());
      if (mismatches == 0 && escaped_chars.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
